// ===== sv/cne_pkg.sv =====
`timescale 1ns / 1ps

package cne_pkg;

   localparam int MANTISSA_SLOTS = 10;
   localparam int SHOWN_SLOTS    = 10;
   localparam int CNT_W          = $clog2(MANTISSA_SLOTS + 1);
   localparam int QUEUE_DEPTH    = 2;

   localparam logic [3:0] EMPTY_NIBBLE = 4'hF;
   localparam logic [3:0] KEY_POINT    = 4'd10;
   localparam logic [3:0] KEY_EEX      = 4'd11;
   localparam logic [3:0] KEY_CHS      = 4'd12;
   localparam logic [7:0] POINT_MAX    = 8'd14;

   typedef enum logic [2:0] {
      OP_END,
      OP_DIGIT,
      OP_POINT,
      OP_EEX,
      OP_CHS,
      OP_NONE
   } op_type;

   typedef struct packed {
      op_type     op;
      logic [3:0] digit;
   } cmd_type;

   typedef struct packed {
      logic [4*SHOWN_SLOTS-1:0] mantissa_digits;
      logic [3:0]               exponent_first;
      logic [3:0]               exponent_second;
      logic                     exponent_mode;
      logic                     mantissa_sign;
      logic                     exponent_sign;
      logic [3:0]               point_position;
      logic                     entry_active;
   } result_type;

endpackage

// ===== sv/cne_front.sv =====
`timescale 1ns / 1ps

module cne_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  logic             req_mode,
   input  logic [3:0]       req_key,
   output logic             cmd_valid,
   output cne_pkg::cmd_type cmd,
   input  logic             cmd_take
);
   import cne_pkg::*;

   cmd_type    slot_ff [QUEUE_DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    new_cmd;
   logic       push_ok;
   logic       pop_ok;

   // classify the key into an operation
   always_comb begin
      new_cmd.digit = req_key;
      if (req_mode) begin
         new_cmd.op = OP_END;
      end else begin
         case (req_key) inside
            [4'd0:4'd9]: new_cmd.op = OP_DIGIT;
            KEY_POINT:   new_cmd.op = OP_POINT;
            KEY_EEX:     new_cmd.op = OP_EEX;
            KEY_CHS:     new_cmd.op = OP_CHS;
            default:     new_cmd.op = OP_NONE;
         endcase
      end
   end

   assign req_full  = (count_ff == 2'(QUEUE_DEPTH));
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign push_ok   = req_push && !req_full;
   assign pop_ok    = cmd_take && cmd_valid;

   always_comb begin
      wr_ptr_in = push_ok ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

// ===== sv/cne_back.sv =====
`timescale 1ns / 1ps

module cne_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                cmd_valid,
   input  cne_pkg::cmd_type    cmd,
   output logic                cmd_take,
   output logic                rsp_empty,
   input  logic                rsp_pop,
   output cne_pkg::result_type rsp_head
);
   import cne_pkg::*;

   // entry buffer
   logic [3:0]       mant_ff [MANTISSA_SLOTS];
   logic [3:0]       mant_in [MANTISSA_SLOTS];
   logic [3:0]       exp0_ff, exp0_in;
   logic [3:0]       exp1_ff, exp1_in;
   logic             exp_flag_ff, exp_flag_in;
   logic             mneg_ff, mneg_in;
   logic             eneg_ff, eneg_in;
   logic [3:0]       point_ff, point_in;
   logic             active_ff, active_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [7:0]       cnt_wide;

   // result queue
   result_type       rslot_ff [QUEUE_DEPTH];
   logic             rwr_ff, rwr_in;
   logic             rrd_ff, rrd_in;
   logic [1:0]       rcount_ff, rcount_in;
   logic             rpop_ok;
   result_type       result;
   logic [4*SHOWN_SLOTS-1:0] shown;

   assign cmd_take = cmd_valid && (rcount_ff != 2'(QUEUE_DEPTH));

   always_comb begin
      mant_in     = mant_ff;
      exp0_in     = exp0_ff;
      exp1_in     = exp1_ff;
      exp_flag_in = exp_flag_ff;
      mneg_in     = mneg_ff;
      eneg_in     = eneg_ff;
      point_in    = point_ff;
      active_in   = active_ff;
      cnt_in      = cnt_ff;
      cnt_wide    = 8'd0;
      if (cmd_take) begin
         if (cmd.op == OP_END) begin
            active_in = 1'b0;
         end else begin
            // first key of an entry: wipe the buffer
            if (!active_ff) begin
               for (int i = 0; i < MANTISSA_SLOTS; i++) begin
                  mant_in[i] = EMPTY_NIBBLE;
               end
               exp0_in     = EMPTY_NIBBLE;
               exp1_in     = EMPTY_NIBBLE;
               exp_flag_in = 1'b0;
               mneg_in     = 1'b0;
               eneg_in     = 1'b0;
               point_in    = EMPTY_NIBBLE;
               cnt_in      = '0;
            end
            active_in = 1'b1;
            case (cmd.op)
               OP_DIGIT: begin
                  if (exp_flag_in) begin
                     if (exp0_in == EMPTY_NIBBLE) begin
                        exp0_in = cmd.digit;
                     end else if (exp1_in == EMPTY_NIBBLE) begin
                        exp1_in = cmd.digit;
                     end
                  end else if (cnt_in < CNT_W'(MANTISSA_SLOTS)) begin
                     for (int i = 0; i < MANTISSA_SLOTS; i++) begin
                        if (cnt_in == CNT_W'(i)) begin
                           mant_in[i] = cmd.digit;
                        end
                     end
                     cnt_in = cnt_in + CNT_W'(1);
                  end
               end
               OP_EEX: exp_flag_in = 1'b1;
               OP_CHS: begin
                  if (exp_flag_in) begin
                     eneg_in = ~eneg_in;
                  end else begin
                     mneg_in = ~mneg_in;
                  end
               end
               OP_POINT: begin
                  if (point_in == EMPTY_NIBBLE && !exp_flag_in) begin
                     cnt_wide = 8'(cnt_in);
                     // clamp so the count never reads as "no point"
                     point_in = (cnt_wide > POINT_MAX) ? POINT_MAX[3:0] : cnt_wide[3:0];
                  end
               end
               default: ;
            endcase
         end
      end
   end

   for (genvar g = 0; g < SHOWN_SLOTS; g++) begin : g_shown
      if (g < MANTISSA_SLOTS) begin : g_slot
         assign shown[4*g +: 4] = mant_in[g];
      end else begin : g_pad
         assign shown[4*g +: 4] = EMPTY_NIBBLE;
      end
   end

   always_comb begin
      result.mantissa_digits = shown;
      result.exponent_first  = exp0_in;
      result.exponent_second = exp1_in;
      result.exponent_mode   = exp_flag_in;
      result.mantissa_sign   = mneg_in;
      result.exponent_sign   = eneg_in;
      result.point_position  = point_in;
      result.entry_active    = active_in;
   end

   assign rsp_empty = (rcount_ff == 2'd0);
   assign rsp_head  = rslot_ff[rrd_ff];
   assign rpop_ok   = rsp_pop && !rsp_empty;

   always_comb begin
      rwr_in    = cmd_take ? ~rwr_ff : rwr_ff;
      rrd_in    = rpop_ok ? ~rrd_ff : rrd_ff;
      rcount_in = rcount_ff + 2'(cmd_take) - 2'(rpop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < MANTISSA_SLOTS; i++) begin
            mant_ff[i] <= EMPTY_NIBBLE;
         end
         exp0_ff     <= EMPTY_NIBBLE;
         exp1_ff     <= EMPTY_NIBBLE;
         exp_flag_ff <= 1'b0;
         mneg_ff     <= 1'b0;
         eneg_ff     <= 1'b0;
         point_ff    <= EMPTY_NIBBLE;
         active_ff   <= 1'b0;
         cnt_ff      <= '0;
         rwr_ff      <= 1'b0;
         rrd_ff      <= 1'b0;
         rcount_ff   <= 2'd0;
      end else begin
         mant_ff     <= mant_in;
         exp0_ff     <= exp0_in;
         exp1_ff     <= exp1_in;
         exp_flag_ff <= exp_flag_in;
         mneg_ff     <= mneg_in;
         eneg_ff     <= eneg_in;
         point_ff    <= point_in;
         active_ff   <= active_in;
         cnt_ff      <= cnt_in;
         rwr_ff      <= rwr_in;
         rrd_ff      <= rrd_in;
         rcount_ff   <= rcount_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_take) begin
         rslot_ff[rwr_ff] <= result;
      end
   end

   // fill count stays within the slot count
   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MANTISSA_SLOTS))
      else $error("mantissa fill count beyond slot count");

   // a recorded point never lies past the digits entered
   assert property (@(posedge clock) disable iff (reset)
      (point_ff != EMPTY_NIBBLE) |-> (8'(point_ff) <= 8'(cnt_ff)))
      else $error("point position past entered digits");

   // exponent digits only exist in exponent mode, and fill in order
   assert property (@(posedge clock) disable iff (reset)
      (!exp_flag_ff |-> (exp0_ff == EMPTY_NIBBLE && exp1_ff == EMPTY_NIBBLE)) and
      ((exp1_ff != EMPTY_NIBBLE) |-> (exp0_ff != EMPTY_NIBBLE)))
      else $error("exponent slots out of order");

   // a taken command always leaves a snapshot in the result queue
   assert property (@(posedge clock) disable iff (reset)
      cmd_take |=> (rcount_ff != 2'd0))
      else $error("taken command left no result");

endmodule

// ===== sv/calculator_number_entry.sv =====
`timescale 1ns / 1ps
// A pushed word sits decoded in the command queue until the back end takes it (only while
// the result queue has room); it is then applied to the buffer and its snapshot queued.
// Throughput: one word per cycle while snapshots are popped as they arrive; the back end
// executes one command per cycle, limited by its single update of the entry buffer.
// Reset (synchronous, active high): both queues empty, buffer slots read 15, flags 0.

module calculator_number_entry (
   input  logic        clock,
   input  logic        reset,
   // key words
   input  logic        req_push,
   output logic        req_full,
   input  logic        req_mode,
   input  logic [3:0]  req_key,
   // buffer snapshots
   output logic        rsp_empty,
   input  logic        rsp_pop,
   output logic [39:0] rsp_mantissa_digits,
   output logic [3:0]  rsp_exponent_first,
   output logic [3:0]  rsp_exponent_second,
   output logic        rsp_exponent_mode,
   output logic        rsp_mantissa_sign,
   output logic        rsp_exponent_sign,
   output logic [3:0]  rsp_point_position,
   output logic        rsp_entry_active
);
   import cne_pkg::*;

   logic       cmd_valid;
   logic       cmd_take;
   cmd_type    cmd;
   result_type rsp_head;

   // front: take key words, decode them into operations, hold them in a short queue
   cne_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_mode  (req_mode),
      .req_key   (req_key),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take)
   );

   // back: apply each operation to the entry buffer and queue the snapshot
   cne_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_take  (cmd_take),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_head  (rsp_head)
   );

   // unpack the head snapshot onto the result ports
   assign rsp_mantissa_digits = rsp_head.mantissa_digits;
   assign rsp_exponent_first  = rsp_head.exponent_first;
   assign rsp_exponent_second = rsp_head.exponent_second;
   assign rsp_exponent_mode   = rsp_head.exponent_mode;
   assign rsp_mantissa_sign   = rsp_head.mantissa_sign;
   assign rsp_exponent_sign   = rsp_head.exponent_sign;
   assign rsp_point_position  = rsp_head.point_position;
   assign rsp_entry_active    = rsp_head.entry_active;

endmodule

// ===== tb/calculator_number_entry_tb.sv =====
`timescale 1ns / 1ps

module calculator_number_entry_tb;
   import cne_pkg::*;

   // Word modes and the keys that only trigger the first-key clear
   localparam logic       MODE_KEY    = 1'b0;
   localparam logic       MODE_END    = 1'b1;
   localparam logic [3:0] KEY_BLANK_A = 4'd13;
   localparam logic [3:0] KEY_BLANK_B = 4'd14;
   localparam logic [3:0] KEY_BLANK_C = 4'd15;
   localparam logic [3:0] POINT_CLAMP = 4'd14;

   localparam int RANDOM_WORDS = 750;
   localparam int STALL_PCT    = 24;
   localparam int STUCK_LIMIT  = 2000;
   localparam int REPORT_MAX   = 10;

   logic        clock;
   logic        reset = 1'b1;
   logic        req_push = 1'b0;
   logic        req_full;
   logic        req_mode = MODE_KEY;
   logic [3:0]  req_key = 4'd0;
   logic        rsp_empty;
   logic        rsp_pop = 1'b0;
   logic [39:0] rsp_mantissa_digits;
   logic [3:0]  rsp_exponent_first;
   logic [3:0]  rsp_exponent_second;
   logic        rsp_exponent_mode;
   logic        rsp_mantissa_sign;
   logic        rsp_exponent_sign;
   logic [3:0]  rsp_point_position;
   logic        rsp_entry_active;

   // Snapshots the buffer must show, oldest first
   result_type snapshot_q[$];

   int  words_sent   = 0;
   int  fail_count   = 0;
   int  stuck_cycles = 0;
   // While set, neither side stalls
   bit  steady       = 1'b0;

   // Own copy of the entry buffer
   logic [3:0] entry_slots [MANTISSA_SLOTS];
   logic [3:0] entry_exp   [2];
   logic       entry_eex;
   logic       entry_mneg;
   logic       entry_eneg;
   logic [3:0] entry_point;
   logic       entry_active;

   calculator_number_entry dut (
      .clock               (clock),
      .reset               (reset),
      .req_push            (req_push),
      .req_full            (req_full),
      .req_mode            (req_mode),
      .req_key             (req_key),
      .rsp_empty           (rsp_empty),
      .rsp_pop             (rsp_pop),
      .rsp_mantissa_digits (rsp_mantissa_digits),
      .rsp_exponent_first  (rsp_exponent_first),
      .rsp_exponent_second (rsp_exponent_second),
      .rsp_exponent_mode   (rsp_exponent_mode),
      .rsp_mantissa_sign   (rsp_mantissa_sign),
      .rsp_exponent_sign   (rsp_exponent_sign),
      .rsp_point_position  (rsp_point_position),
      .rsp_entry_active    (rsp_entry_active)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // ---------------------------------------------------------------
   // Entry buffer predictor
   // ---------------------------------------------------------------

   // Empty every slot and drop signs, exponent mode and the point
   function automatic void clear_entry();
      for (int i = 0; i < MANTISSA_SLOTS; i++) entry_slots[i] = EMPTY_NIBBLE;
      entry_exp[0] = EMPTY_NIBBLE;
      entry_exp[1] = EMPTY_NIBBLE;
      entry_eex    = 1'b0;
      entry_mneg   = 1'b0;
      entry_eneg   = 1'b0;
      entry_point  = EMPTY_NIBBLE;
   endfunction

   // Lowest empty mantissa slot, MANTISSA_SLOTS when all are filled
   function automatic int first_open_slot();
      int p;
      p = 0;
      while (p < MANTISSA_SLOTS && entry_slots[p] != EMPTY_NIBBLE) p++;
      return p;
   endfunction

   // Apply one word to the buffer and return the snapshot it shows
   function automatic result_type advance_entry(logic mode, logic [3:0] key);
      result_type snap;
      int         p;
      if (mode == MODE_END) begin
         entry_active = 1'b0;
      end else begin
         // The first key of an entry wipes the buffer, whatever the key is
         if (!entry_active) begin
            clear_entry();
            entry_active = 1'b1;
         end
         if (key < KEY_POINT) begin
            if (entry_eex) begin
               if (entry_exp[0] == EMPTY_NIBBLE) entry_exp[0] = key;
               else if (entry_exp[1] == EMPTY_NIBBLE) entry_exp[1] = key;
            end else begin
               p = first_open_slot();
               if (p < MANTISSA_SLOTS) entry_slots[p] = key;
            end
         end else if (key == KEY_EEX) begin
            entry_eex = 1'b1;
         end else if (key == KEY_CHS) begin
            if (entry_eex) entry_eneg = ~entry_eneg;
            else entry_mneg = ~entry_mneg;
         end else if (key == KEY_POINT) begin
            // Record the point once, never in exponent mode; keep clear of the no-point code
            if (entry_point == EMPTY_NIBBLE && !entry_eex) begin
               p = first_open_slot();
               entry_point = (p > POINT_CLAMP) ? POINT_CLAMP : 4'(p);
            end
         end
      end
      for (int i = 0; i < SHOWN_SLOTS; i++) begin
         if (i < MANTISSA_SLOTS) snap.mantissa_digits[4*i +: 4] = entry_slots[i];
         else snap.mantissa_digits[4*i +: 4] = EMPTY_NIBBLE;
      end
      snap.exponent_first  = entry_exp[0];
      snap.exponent_second = entry_exp[1];
      snap.exponent_mode   = entry_eex;
      snap.mantissa_sign   = entry_mneg;
      snap.exponent_sign   = entry_eneg;
      snap.point_position  = entry_point;
      snap.entry_active    = entry_active;
      return snap;
   endfunction

   // ---------------------------------------------------------------
   // Sender
   // ---------------------------------------------------------------

   // Present one word at the falling edge, hold it until accepted, then predict.
   // Leave push high afterwards so back-to-back words need no second assignment.
   task automatic send_word(input logic mode, input logic [3:0] key);
      while (!steady && $urandom_range(99) < STALL_PCT) begin
         req_push <= 1'b0;
         @(negedge clock);
      end
      req_push <= 1'b1;
      req_mode <= mode;
      req_key  <= key;
      do @(posedge clock); while (req_full);
      snapshot_q.push_back(advance_entry(mode, key));
      words_sent++;
      @(negedge clock);
   endtask

   // Drop push and hold off until every snapshot has come back
   task automatic wait_for_snapshots();
      req_push <= 1'b0;
      do @(negedge clock); while (snapshot_q.size() != 0);
   endtask

   // ---------------------------------------------------------------
   // Receiver and checker
   // ---------------------------------------------------------------

   // Stall the result side at random, except during the steady stretch
   always @(negedge clock) begin
      rsp_pop <= !reset && (steady || $urandom_range(99) >= STALL_PCT);
   end

   always @(posedge clock) begin
      result_type seen;
      result_type want;
      string      bad;
      if (!reset && rsp_pop && !rsp_empty) begin
         seen.mantissa_digits = rsp_mantissa_digits;
         seen.exponent_first  = rsp_exponent_first;
         seen.exponent_second = rsp_exponent_second;
         seen.exponent_mode   = rsp_exponent_mode;
         seen.mantissa_sign   = rsp_mantissa_sign;
         seen.exponent_sign   = rsp_exponent_sign;
         seen.point_position  = rsp_point_position;
         seen.entry_active    = rsp_entry_active;
         if (snapshot_q.size() == 0) begin
            fail_count++;
            if (fail_count <= REPORT_MAX)
               $display("%0t: snapshot with none expected: mant=%h", $realtime,
                        seen.mantissa_digits);
         end else begin
            want = snapshot_q.pop_front();
            bad  = "";
            if (seen.mantissa_digits !== want.mantissa_digits) bad = {bad, " mantissa_digits"};
            if (seen.exponent_first !== want.exponent_first)   bad = {bad, " exponent_first"};
            if (seen.exponent_second !== want.exponent_second) bad = {bad, " exponent_second"};
            if (seen.exponent_mode !== want.exponent_mode)     bad = {bad, " exponent_mode"};
            if (seen.mantissa_sign !== want.mantissa_sign)     bad = {bad, " mantissa_sign"};
            if (seen.exponent_sign !== want.exponent_sign)     bad = {bad, " exponent_sign"};
            if (seen.point_position !== want.point_position)   bad = {bad, " point_position"};
            if (seen.entry_active !== want.entry_active)       bad = {bad, " entry_active"};
            if (bad != "") begin
               fail_count++;
               if (fail_count <= REPORT_MAX) begin
                  $display("%0t: snapshot mismatch in%s", $realtime, bad);
                  $display("   expected mant=%h exp=%h%h eex=%b sgn=%b%b pt=%h act=%b",
                           want.mantissa_digits, want.exponent_first,
                           want.exponent_second, want.exponent_mode,
                           want.mantissa_sign, want.exponent_sign,
                           want.point_position, want.entry_active);
                  $display("   actual   mant=%h exp=%h%h eex=%b sgn=%b%b pt=%h act=%b",
                           seen.mantissa_digits, seen.exponent_first,
                           seen.exponent_second, seen.exponent_mode,
                           seen.mantissa_sign, seen.exponent_sign,
                           seen.point_position, seen.entry_active);
               end
            end
         end
      end
   end

   // Stop a hung run: count cycles in which neither side moves a word
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
         if (stuck_cycles >= STUCK_LIMIT) begin
            $display("calculator_number_entry_tb failed");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------

   // Fill past the last slot, signs on both halves, repeated EEX, exponent overflow
   task automatic test_digit_fill_and_signs();
      send_word(MODE_KEY, KEY_BLANK_A);          // first key with no effect of its own
      for (int d = 0; d < 10; d++) send_word(MODE_KEY, 4'(d));
      send_word(MODE_KEY, 4'd5);                 // buffer full: drop digit
      send_word(MODE_KEY, KEY_POINT);            // point after every slot filled
      send_word(MODE_KEY, KEY_CHS);
      send_word(MODE_KEY, KEY_EEX);
      send_word(MODE_KEY, KEY_EEX);              // repeated EEX
      send_word(MODE_KEY, KEY_POINT);            // point in exponent mode
      send_word(MODE_KEY, KEY_CHS);
      send_word(MODE_KEY, 4'd9);
      send_word(MODE_KEY, 4'd0);
      send_word(MODE_KEY, 4'd3);                 // exponent full
      send_word(MODE_END, KEY_BLANK_C);          // end keeps the buffer
   endtask

   // Point as first key, repeated point, blank keys, end with a digit key
   task automatic test_point_and_first_key();
      send_word(MODE_KEY, KEY_POINT);
      send_word(MODE_KEY, KEY_POINT);
      send_word(MODE_KEY, 4'd7);
      send_word(MODE_KEY, KEY_BLANK_B);
      send_word(MODE_KEY, KEY_BLANK_C);
      send_word(MODE_END, 4'd0);
      send_word(MODE_END, KEY_EEX);              // second end in a row
   endtask

   // One well-formed entry with random content, closed by an end word
   task automatic send_random_entry();
      int ndig;
      int point_at;
      int nexp;
      ndig     = ($urandom_range(7) == 0) ? $urandom_range(10, 13) : $urandom_range(0, 9);
      point_at = $urandom_range(0, ndig + 3);    // past ndig: no point
      if ($urandom_range(3) == 0) send_word(MODE_KEY, KEY_CHS);
      for (int i = 0; i < ndig; i++) begin
         if (i == point_at) send_word(MODE_KEY, KEY_POINT);
         send_word(MODE_KEY, 4'($urandom_range(9)));
         if ($urandom_range(9) == 0) send_word(MODE_KEY, KEY_CHS);
         if ($urandom_range(15) == 0) send_word(MODE_KEY, KEY_POINT);
      end
      if (point_at == ndig) send_word(MODE_KEY, KEY_POINT);
      if ($urandom_range(1)) begin
         send_word(MODE_KEY, KEY_EEX);
         nexp = $urandom_range(0, 3);
         for (int i = 0; i < nexp; i++) begin
            if ($urandom_range(3) == 0) send_word(MODE_KEY, KEY_CHS);
            if ($urandom_range(9) == 0) send_word(MODE_KEY, KEY_EEX);
            if ($urandom_range(9) == 0) send_word(MODE_KEY, KEY_POINT);
            send_word(MODE_KEY, 4'($urandom_range(9)));
         end
      end
      send_word(MODE_END, 4'($urandom_range(15)));
   endtask

   // Mostly well-formed entries, some raw noise, one steady stretch, one drain pause
   task automatic test_random_entries();
      int goal;
      int n;
      bit paused;
      goal   = words_sent + RANDOM_WORDS;
      paused = 1'b0;
      while (words_sent < goal) begin
         steady = (goal - words_sent) inside {[250 : 400]};
         if (!paused && goal - words_sent < RANDOM_WORDS / 2) begin
            wait_for_snapshots();
            paused = 1'b1;
         end
         if ($urandom_range(4) == 0) begin
            n = $urandom_range(1, 4);
            repeat (n)
               send_word(($urandom_range(5) == 0) ? MODE_END : MODE_KEY,
                         4'($urandom_range(15)));
         end else begin
            send_random_entry();
         end
      end
      steady = 1'b0;
   endtask

   // ---------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------

   initial begin
      clear_entry();
      entry_active = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_digit_fill_and_signs();
      test_point_and_first_key();
      test_random_entries();

      // Drain, then keep the clock running so the pipeline can show any stray word
      wait_for_snapshots();
      repeat (8) @(posedge clock);

      if (fail_count == 0 && snapshot_q.size() == 0)
         $display("calculator_number_entry_tb passed");
      else
         $display("calculator_number_entry_tb failed");
      $finish;
   end

endmodule
